@@ rtl/lfia_pkg.sv @@
// ============================================================================
// lfia_pkg
// Shared types, constants and helpers for the lowest-free ID allocator.
// ============================================================================
package lfia_pkg;

    // Payload widths fixed by the channel definitions.
    localparam int REQ_ID_W = 10;
    localparam int FUNC_W   = 2;

    // Default pool size.
    localparam int ID_COUNT_DEF = 1024;

    // The used bitmap is held as words of this many bits.
    localparam int WORD_W  = 32;
    localparam int WORD_LW = 5;

    // Operation codes carried in the func field.
    typedef enum logic [FUNC_W-1:0] {
        FUNC_ALLOC   = 2'd0,
        FUNC_CLAIM   = 2'd1,
        FUNC_RELEASE = 2'd2
    } func_t;

    // Sequencer states.
    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_MOD,
        ST_SCAN,
        ST_RESP
    } state_t;

    // Index of the lowest set bit of a bitmap word (zero when none is set).
    function automatic logic [WORD_LW-1:0] lowest_set_index(input logic [WORD_W-1:0] w);
        logic [WORD_W-1:0]  iso;
        logic [WORD_LW-1:0] idx;
        iso = w & (~w + WORD_W'(1));
        idx = '0;
        for (int i = 0; i < WORD_W; i++)
        begin
            if (iso[i])
            begin
                idx = idx | WORD_LW'(i);
            end
        end
        return idx;
    endfunction

endpackage

@@ rtl/lfia_if.sv @@
// ============================================================================
// lfia_if
// Request and response channel interfaces of the lowest-free ID allocator.
// ============================================================================
interface lfia_req_if;
    logic                           valid;
    logic                           ready;
    logic [lfia_pkg::FUNC_W-1:0]    func;
    logic [lfia_pkg::REQ_ID_W-1:0]  req_id;

    modport source (output valid, output func, output req_id, input ready);
    modport sink   (input valid, input func, input req_id, output ready);
endinterface

interface lfia_rsp_if;
    logic                           valid;
    logic                           ready;
    logic [lfia_pkg::REQ_ID_W-1:0]  result_id;
    logic                           ok;

    modport source (output valid, output result_id, output ok, input ready);
    modport sink   (input valid, input result_id, input ok, output ready);
endinterface

@@ rtl/lowest_free_id_allocator_unit.sv @@
// Flow: a request that reads the bitmap goes from IDLE to MOD, which may update
// the target word, then to SCAN if the search must read further words (32 IDs
// each), then to RESP; any other request goes from IDLE straight to RESP.
// Throughput: one request in flight at a time; the next request is taken in the
// cycle after the response is loaded into the output register.
// Reset: the pointer clears at once; a clearing pass then writes one bitmap word
// a cycle over all ceil(ID_COUNT/32) words (32 by default) before any request is taken.
// ============================================================================
// lowest_free_id_allocator_unit
// Pool of ID_COUNT identifiers kept as a used bitmap in a word-wide memory and
// a lowest-free pointer, served by a small sequencer and a word-wide search.
// ============================================================================
module lowest_free_id_allocator_unit #(
    parameter int ID_COUNT = lfia_pkg::ID_COUNT_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    lfia_req_if.sink    req,
    lfia_rsp_if.source  rsp
);
    import lfia_pkg::*;

    // Pointer width: must hold ID_COUNT itself (pool full) and any req_id, so
    // that the range check on a request is a plain compare.
    localparam int PTR_NAT  = $clog2(ID_COUNT + 1);
    localparam int ID_W     = (PTR_NAT > REQ_ID_W + 1) ? PTR_NAT : REQ_ID_W + 1;
    // Word index width, able to reach one past the last word.
    localparam int WI_W     = ID_W - WORD_LW;
    localparam int ID_WORDS = (ID_COUNT + WORD_W - 1) / WORD_W;
    localparam int AW       = (ID_WORDS > 1) ? $clog2(ID_WORDS) : 1;
    localparam int REM_BITS = ID_COUNT % WORD_W;
    // Bits of the last word that stand for real identifiers.
    localparam logic [WORD_W-1:0] LAST_MASK =
        (REM_BITS == 0) ? {WORD_W{1'b1}} : ((WORD_W'(1) << REM_BITS) - WORD_W'(1));

    // ------------------------------------------------------------------
    // State
    // ------------------------------------------------------------------
    state_t                 state_reg, state_next;
    logic [ID_W-1:0]        lowest_free_reg, lowest_free_next;
    logic [FUNC_W-1:0]      func_reg, func_next;
    logic [ID_W-1:0]        tgt_reg, tgt_next;
    logic [REQ_ID_W-1:0]    res_reg, res_next;
    logic                   ok_reg, ok_next;
    logic [WI_W-1:0]        wd_reg, wd_next;
    logic [AW-1:0]          clr_reg, clr_next;
    logic                   out_valid_reg, out_valid_next;
    logic [REQ_ID_W-1:0]    out_id_reg, out_id_next;
    logic                   out_ok_reg, out_ok_next;

    // Bitmap memory: one write and one read port, registered read data.
    logic [WORD_W-1:0]      bitmap_mem [ID_WORDS];
    logic [WORD_W-1:0]      rdata_reg;
    logic                   mem_we, mem_re;
    logic [AW-1:0]          mem_waddr, mem_raddr;
    logic [WORD_W-1:0]      mem_wdata;

    // Helpers for the word that holds the target identifier.
    logic [ID_W-1:0]        req_tgt;
    logic [WORD_LW-1:0]     bitpos;
    logic [WORD_W-1:0]      onehot;
    logic [WI_W-1:0]        twd;
    logic [WI_W-1:0]        twd_inc;
    logic [WI_W-1:0]        wd_inc;
    logic [WORD_W-1:0]      set_word;
    logic [WORD_W-1:0]      free_here;
    logic [WORD_W-1:0]      free_scan;
    logic                   need_scan;
    logic                   load_out;

    function automatic logic [WORD_W-1:0] word_mask(input logic [WI_W-1:0] w);
        return (w == WI_W'(ID_WORDS - 1)) ? LAST_MASK : {WORD_W{1'b1}};
    endfunction

    assign req_tgt   = ID_W'(req.req_id);
    assign bitpos    = tgt_reg[WORD_LW-1:0];
    assign onehot    = WORD_W'(1) << bitpos;
    assign twd       = tgt_reg[ID_W-1:WORD_LW];
    assign twd_inc   = twd + WI_W'(1);
    assign wd_inc    = wd_reg + WI_W'(1);
    assign set_word  = rdata_reg | onehot;
    // Free identifiers strictly above the target in its own word.
    assign free_here = ~set_word & (~WORD_W'(1) << bitpos) & word_mask(twd);
    // Free identifiers in the word fetched by the upward search.
    assign free_scan = ~rdata_reg & word_mask(wd_reg);
    assign load_out  = (state_reg == ST_RESP) && (!out_valid_reg || rsp.ready);

    assign req.ready     = (state_reg == ST_IDLE);
    assign rsp.valid     = out_valid_reg;
    assign rsp.result_id = out_id_reg;
    assign rsp.ok        = out_ok_reg;

    // ------------------------------------------------------------------
    // Bitmap memory
    // ------------------------------------------------------------------
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            bitmap_mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= bitmap_mem[mem_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_CLEAR;
            lowest_free_reg <= '0;
            clr_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            lowest_free_reg <= lowest_free_next;
            clr_reg         <= clr_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        func_reg   <= func_next;
        tgt_reg    <= tgt_next;
        res_reg    <= res_next;
        ok_reg     <= ok_next;
        wd_reg     <= wd_next;
        out_id_reg <= out_id_next;
        out_ok_reg <= out_ok_next;
    end

    // ------------------------------------------------------------------
    // Sequencer
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next       = state_reg;
        lowest_free_next = lowest_free_reg;
        func_next        = func_reg;
        tgt_next         = tgt_reg;
        res_next         = res_reg;
        ok_next          = ok_reg;
        wd_next          = wd_reg;
        clr_next         = clr_reg;
        out_valid_next   = out_valid_reg;
        out_id_next      = out_id_reg;
        out_ok_next      = out_ok_reg;
        mem_we           = 1'b0;
        mem_waddr        = twd[AW-1:0];
        mem_wdata        = set_word;
        mem_re           = 1'b0;
        mem_raddr        = twd[AW-1:0];
        need_scan        = 1'b0;

        // The consumer takes the held response.
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_CLEAR:
            begin
                // Write the bitmap to all free, one word a cycle.
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + AW'(1);
                if (clr_reg == AW'(ID_WORDS - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next  = req.func;
                    res_next   = req.req_id;
                    ok_next    = 1'b0;
                    state_next = ST_RESP;
                    case (req.func)
                        FUNC_ALLOC:
                        begin
                            tgt_next = lowest_free_reg;
                            if (lowest_free_reg == ID_W'(ID_COUNT))
                            begin
                                res_next = '0;
                            end
                            else
                            begin
                                res_next   = lowest_free_reg[REQ_ID_W-1:0];
                                mem_re     = 1'b1;
                                mem_raddr  = lowest_free_reg[WORD_LW+AW-1:WORD_LW];
                                state_next = ST_MOD;
                            end
                        end
                        FUNC_CLAIM, FUNC_RELEASE:
                        begin
                            tgt_next = req_tgt;
                            if (req_tgt < ID_W'(ID_COUNT))
                            begin
                                mem_re     = 1'b1;
                                mem_raddr  = req_tgt[WORD_LW+AW-1:WORD_LW];
                                state_next = ST_MOD;
                            end
                            else if (req.func == FUNC_RELEASE)
                            begin
                                // Release beyond the pool is ignored but succeeds.
                                ok_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            ok_next = 1'b0;
                        end
                    endcase
                end
            end

            ST_MOD:
            begin
                // Read-modify-write of the target word.
                state_next = ST_RESP;
                case (func_reg)
                    FUNC_ALLOC:
                    begin
                        mem_we    = 1'b1;
                        ok_next   = 1'b1;
                        need_scan = 1'b1;
                    end
                    FUNC_CLAIM:
                    begin
                        if (!(|(rdata_reg & onehot)))
                        begin
                            mem_we    = 1'b1;
                            ok_next   = 1'b1;
                            need_scan = (tgt_reg == lowest_free_reg);
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        mem_we    = 1'b1;
                        mem_wdata = rdata_reg & ~onehot;
                        ok_next   = 1'b1;
                        if (tgt_reg < lowest_free_reg)
                        begin
                            lowest_free_next = tgt_reg;
                        end
                    end
                    default:
                    begin
                        ok_next = 1'b0;
                    end
                endcase

                if (need_scan)
                begin
                    if (|free_here)
                    begin
                        lowest_free_next = {twd, lowest_set_index(free_here)};
                    end
                    else if (twd_inc == WI_W'(ID_WORDS))
                    begin
                        lowest_free_next = ID_W'(ID_COUNT);
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        mem_raddr  = twd_inc[AW-1:0];
                        wd_next    = twd_inc;
                        state_next = ST_SCAN;
                    end
                end
            end

            ST_SCAN:
            begin
                // Check one word a cycle while fetching the next one.
                if (|free_scan)
                begin
                    lowest_free_next = {wd_reg, lowest_set_index(free_scan)};
                    state_next       = ST_RESP;
                end
                else if (wd_inc == WI_W'(ID_WORDS))
                begin
                    lowest_free_next = ID_W'(ID_COUNT);
                    state_next       = ST_RESP;
                end
                else
                begin
                    mem_re    = 1'b1;
                    mem_raddr = wd_inc[AW-1:0];
                    wd_next   = wd_inc;
                end
            end

            ST_RESP:
            begin
                // Hand the result to the output register once it is free.
                if (load_out)
                begin
                    out_valid_next = 1'b1;
                    out_id_next    = res_reg;
                    out_ok_next    = ok_reg;
                    state_next     = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // The pointer never goes past the pool size.
    a_ptr_range: assert property (@(posedge clk) disable iff (!rst_n)
        lowest_free_reg <= ID_W'(ID_COUNT))
        else $error("lowest-free pointer beyond pool size");

    // No request is taken while the clearing pass is running.
    a_no_req_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CLEAR) |-> !req.ready)
        else $error("request transfer during clearing pass");

    // A finished result shows up on the response channel in the next cycle.
    a_resp_follows: assert property (@(posedge clk) disable iff (!rst_n)
        load_out |=> (rsp.valid && (rsp.result_id == $past(res_reg))))
        else $error("finished result not presented");

    // The search only walks words inside the bitmap.
    a_scan_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_SCAN) |-> (wd_reg < WI_W'(ID_WORDS)))
        else $error("scan word index out of range");

endmodule
